// ----- sv/xor_checked_frame_receiver_macros.svh -----
// Assertion macros for the xor checked frame receiver checker.
// Included by files that hold concurrent assertions; no other dependencies.
`ifndef XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define XOR_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Plain implication check, clocked on the rising edge, off during reset.
`define XCFR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle check: cond at one edge implies prop at the following edge.
`define XCFR_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- sv/xcfr_pkg.sv -----
// Shared types and constants for the xor checked frame receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package xcfr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int CNT_W       = 6;
  localparam int IDX_W       = 5;
  localparam int MEM_AW      = 7;   // bank bit + 6 bit entry index

  localparam logic [7:0] REPLY_BASE = 8'h02;

  localparam logic [1:0] ACT_RECV  = 2'd0;
  localparam logic [1:0] ACT_REPLY = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_REPLY  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_CSUM = 2'd2;

  localparam logic [1:0] REG_END_MASK = 2'd0;
  localparam logic [1:0] REG_CMD_MASK = 2'd1;

  localparam logic [1:0] LAST_SINGLE = 2'd0;
  localparam logic [1:0] LAST_REPLY  = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [CNT_W-1:0] plen;
    logic [7:0]       fcount;
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic [1:0]       nlast;   // index of the final beat
  } job_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
  } mem_rd_t;

endpackage

`default_nettype wire

// ----- sv/xor_checked_frame_receiver.sv -----
// Top level of the xor checked frame receiver: config registers and stream ports.
// Depends on xcfr_pkg, xcfr_ctrl, xcfr_bank_mem and xcfr_out.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tuser action, tlast frame_end, tdata bytes
//  m_axis    out  m_axis_tvalid/tready   tuser out_kind, tlast last_of_run, tdata
//  cfg       in   cfg_we                 cfg_index, cfg_wdata
//
// Frame bytes and payload reads are taken one item per cycle while the output is not
// stalled; a reply item holds the job register until all four reply bytes are out.
// A result passes from the job register and the payload memory read, which capture at
// the accepting edge, to the output register, which loads once the output is free.
// Reset (rst, synchronous) clears frame state, counters and bank select, and presets config.
// The payload memory has no reset; no clearing pass is run.
// A stalled output holds one result and the job register one more job; with both
// full, s_axis_tready drops, also for frame bytes that give no result.
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_frame_receiver
  import xcfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // data_byte[7:0], reply_ok[15:8], read_index[20:16]
  input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
  input  wire logic        s_axis_tlast,   // frame_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // status[1:0], payload_length[7:2],
                                           // frame_count[15:8], out_byte[23:16]
  output logic [1:0]       m_axis_tuser,   // out_kind[1:0]
  output logic             m_axis_tlast,   // last_of_run
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  logic [7:0] end_mask;
  logic [7:0] cmd_mask;

  logic       accept;
  logic       take;
  logic       job_load;
  job_t       job;
  mem_wr_t    wr;
  mem_rd_t    rd;
  logic [7:0] rdata;

  logic [1:0]       o_status;
  logic [CNT_W-1:0] o_plen;
  logic [7:0]       o_fcount;
  logic [7:0]       o_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_mask <= 8'h80;
      cmd_mask <= 8'h40;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_END_MASK: end_mask <= cfg_wdata;
        REG_CMD_MASK: cmd_mask <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = take;
  assign accept        = s_axis_tvalid && take;

  xcfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (s_axis_tuser),
    .data_byte  (s_axis_tdata[7:0]),
    .frame_end  (s_axis_tlast),
    .reply_ok   (s_axis_tdata[15:8]),
    .read_index (s_axis_tdata[20:16]),
    .end_mask   (end_mask),
    .cmd_mask   (cmd_mask),
    .wr         (wr),
    .rd         (rd),
    .job_load   (job_load),
    .job        (job)
  );

  xcfr_bank_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  xcfr_out u_out (
    .clk      (clk),
    .rst      (rst),
    .job_load (job_load),
    .job_in   (job),
    .rdata    (rdata),
    .take     (take),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_kind   (m_axis_tuser),
    .m_status (o_status),
    .m_plen   (o_plen),
    .m_fcount (o_fcount),
    .m_byte   (o_byte),
    .m_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {o_byte, o_fcount, o_plen, o_status};

endmodule

`default_nettype wire

// ----- sv/xcfr_bank_mem.sv -----
// Double-buffered payload store: two banks of 64 bytes, one write and one read port.
// Depends on xcfr_pkg; read data is registered and holds between reads.
`timescale 1ns / 1ps
`default_nettype none

module xcfr_bank_mem
  import xcfr_pkg::*;
(
  input  wire logic    clk,
  input  wire mem_wr_t wr,
  input  wire mem_rd_t rd,
  output logic [7:0]   rdata
);

  logic [7:0] mem [0:(1 << MEM_AW) - 1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/xcfr_ctrl.sv -----
// Frame tracking: header capture, running xor, byte count, commit and bank swap.
// Depends on xcfr_pkg; drives the payload memory ports and builds a job for each frame end, reply and read.
`timescale 1ns / 1ps
`default_nettype none

module xcfr_ctrl
  import xcfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [1:0]       action,
  input  wire logic [7:0]       data_byte,
  input  wire logic             frame_end,
  input  wire logic [7:0]       reply_ok,
  input  wire logic [IDX_W-1:0] read_index,
  input  wire logic [7:0]       end_mask,
  input  wire logic [7:0]       cmd_mask,
  output mem_wr_t               wr,
  output mem_rd_t               rd,
  output logic                  job_load,
  output job_t                  job
);

  logic [7:0]       running_xor, running_xor_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             overflow, overflow_next;
  logic [7:0]       header, header_next;
  logic             header_seen, header_seen_next;
  logic             bank, bank_next;
  logic [CNT_W-1:0] committed, committed_next;
  logic [7:0]       frames, frames_next;

  logic [1:0] st;
  logic       commit;
  logic       full;

  assign full = byte_count >= CNT_W'(MAX_PAYLOAD);

  always_comb begin
    if (!header_seen || overflow) begin
      st = ST_LEN;
    end else if (data_byte != running_xor) begin
      st = ST_CSUM;
    end else if (header[CNT_W-1:0] != byte_count) begin
      st = ST_LEN;
    end else begin
      st = ST_OK;
    end
    commit = (st == ST_OK) && ((header & end_mask) != 8'd0) &&
             ((header & cmd_mask) == 8'd0);
  end

  always_comb begin
    running_xor_next = running_xor;
    byte_count_next  = byte_count;
    overflow_next    = overflow;
    header_next      = header;
    header_seen_next = header_seen;
    bank_next        = bank;
    committed_next   = committed;
    frames_next      = frames;

    wr.en   = 1'b0;
    wr.addr = {~bank, byte_count};
    wr.data = data_byte;
    rd.en   = 1'b0;
    rd.addr = {bank, 1'b0, read_index};

    job_load   = 1'b0;
    job.kind   = KIND_STATUS;
    job.status = ST_OK;
    job.plen   = committed;
    job.fcount = frames;
    job.b0     = REPLY_BASE | end_mask;
    job.b1     = frames;
    job.b2     = reply_ok;
    job.nlast  = LAST_SINGLE;

    if (accept) begin
      unique case (action)
        ACT_RECV: begin
          if (!frame_end) begin
            if (!header_seen) begin
              header_next      = data_byte;
              running_xor_next = data_byte;
              header_seen_next = 1'b1;
            end else begin
              running_xor_next = running_xor ^ data_byte;
              if (full) begin
                overflow_next = 1'b1;
              end else begin
                wr.en           = 1'b1;
                byte_count_next = byte_count + CNT_W'(1);
              end
            end
          end else begin
            if (commit) begin
              frames_next    = frames + 8'd1;
              committed_next = byte_count;
              bank_next      = ~bank;
            end
            // every frame end starts a fresh frame
            running_xor_next = 8'd0;
            byte_count_next  = '0;
            overflow_next    = 1'b0;
            header_seen_next = 1'b0;
            job_load   = 1'b1;
            job.kind   = KIND_STATUS;
            job.status = st;
            job.plen   = committed_next;
            job.fcount = frames_next;
          end
        end
        ACT_REPLY: begin
          job_load  = 1'b1;
          job.kind  = KIND_REPLY;
          job.nlast = LAST_REPLY;
        end
        ACT_READ: begin
          rd.en    = 1'b1;
          job_load = 1'b1;
          job.kind = KIND_READ;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor <= 8'd0;
      byte_count  <= '0;
      overflow    <= 1'b0;
      header      <= 8'd0;
      header_seen <= 1'b0;
      bank        <= 1'b0;
      committed   <= '0;
      frames      <= 8'd0;
    end else begin
      running_xor <= running_xor_next;
      byte_count  <= byte_count_next;
      overflow    <= overflow_next;
      header      <= header_next;
      header_seen <= header_seen_next;
      bank        <= bank_next;
      committed   <= committed_next;
      frames      <= frames_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/xcfr_out.sv -----
// Result sequencer: one job register and an output register, up to four beats per job.
// Depends on xcfr_pkg; takes payload read data straight from the bank memory.
`timescale 1ns / 1ps
`default_nettype none

module xcfr_out
  import xcfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       job_load,
  input  wire job_t       job_in,
  input  wire logic [7:0] rdata,
  output logic            take,      // job register can take a job this cycle
  output logic            m_valid,
  input  wire logic       m_ready,
  output logic [1:0]      m_kind,
  output logic [1:0]      m_status,
  output logic [CNT_W-1:0] m_plen,
  output logic [7:0]      m_fcount,
  output logic [7:0]      m_byte,
  output logic            m_last
);

  logic       a_valid;
  job_t       job;
  logic [1:0] beat;

  logic       out_free;
  logic       load_beat;
  logic       beat_last;
  logic [7:0] beat_byte;

  assign out_free  = !m_valid || m_ready;
  assign load_beat = a_valid && out_free;
  assign beat_last = beat == job.nlast;
  assign take      = !a_valid || (load_beat && beat_last);

  always_comb begin
    unique case (job.kind)
      KIND_READ: beat_byte = rdata;
      KIND_REPLY: begin
        case (beat)
          2'd0:    beat_byte = job.b0;
          2'd1:    beat_byte = job.b1;
          2'd2:    beat_byte = job.b2;
          default: beat_byte = job.b0 ^ job.b1 ^ job.b2;
        endcase
      end
      default: beat_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      beat    <= 2'd0;
      m_valid <= 1'b0;
    end else begin
      if (job_load) begin
        a_valid <= 1'b1;
        beat    <= 2'd0;
      end else if (load_beat) begin
        if (beat_last) begin
          a_valid <= 1'b0;
          beat    <= 2'd0;
        end else begin
          beat <= beat + 2'd1;
        end
      end
      if (load_beat) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end
    if (load_beat) begin
      m_kind   <= job.kind;
      m_status <= job.status;
      m_plen   <= job.plen;
      m_fcount <= job.fcount;
      m_byte   <= beat_byte;
      m_last   <= beat_last;
    end
  end

endmodule

`default_nettype wire

// ----- sv/xcfr_checker.sv -----
// Port-level checks for the xor checked frame receiver, bound to the top level.
// Depends on xcfr_pkg and xor_checked_frame_receiver_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "xor_checked_frame_receiver_macros.svh"

module xcfr_checker
  import xcfr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_index,
  input wire logic [7:0]  cfg_wdata
);

  // only reply runs span more than one item
  `XCFR_ASSERT(a_multi_beat_is_reply, clk, rst, (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == KIND_REPLY), "non-last item outside a reply")

  // reply and read items carry a zero status
  `XCFR_ASSERT(a_status_only_on_frames, clk, rst, (m_axis_tvalid && m_axis_tuser != KIND_STATUS) |-> (m_axis_tdata[1:0] == ST_OK), "status set on reply or read item")

  // committed length never exceeds the payload limit
  `XCFR_ASSERT(a_length_bound, clk, rst, m_axis_tvalid |-> (m_axis_tdata[7:2] <= 6'(MAX_PAYLOAD)), "committed length above limit")

  // a stalled result holds
  `XCFR_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output item changed")

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_we        (cfg_we),
  .cfg_index     (cfg_index),
  .cfg_wdata     (cfg_wdata)
);

`default_nettype wire
